### rtl/bmn_pkg.sv
// shared types, constants and the divisor table of the 3x3 box mean filter
package bmn_pkg;

  localparam int PW         = 16;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 12;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int FW_RESET   = 1024;
  localparam int FH_RESET   = 4096;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // result kinds a pixel can cause, in emission order
  localparam int RES_INNER  = 0;
  localparam int RES_RIGHT  = 1;
  localparam int RES_BOTTOM = 2;
  localparam int RES_CORNER = 3;

  localparam int QDEPTH   = 4;
  localparam int COLSUM_W = 18;
  localparam int SUM_W    = 20;
  localparam int RECIP_W  = 25;
  localparam int PROD_W   = SUM_W + RECIP_W;
  localparam int QSHIFT   = 24;

  // reciprocals scaled by 2^24, exact for dividends below 2^20
  localparam logic [RECIP_W-1:0] RECIP_1 = 25'd16777216;
  localparam logic [RECIP_W-1:0] RECIP_2 = 25'd8388608;
  localparam logic [RECIP_W-1:0] RECIP_4 = 25'd4194304;
  localparam logic [RECIP_W-1:0] RECIP_3 = 25'd5592406;
  localparam logic [RECIP_W-1:0] RECIP_9 = 25'd1864136;

  // [column][row][bit]: column 0 is x-2, 2 is x; row 0 is y-2, 2 is y
  typedef logic [2:0][2:0][PW-1:0] pix_grid_t;

  typedef struct packed {
    logic [3:0]       pres;
    logic [2:0]       cmask;
    logic [2:0]       rmask;
    logic [COL_W-1:0] col_cur;
    logic [COL_W-1:0] col_prv;
    logic [ROW_W-1:0] row_cur;
    logic [ROW_W-1:0] row_prv;
    pix_grid_t        grid;
  } entry_t;

  typedef struct packed {
    logic [RECIP_W-1:0] mult;
    logic               extra;
  } recip_t;

  function automatic recip_t recip_of(input logic [3:0] n);
    recip_t r;
    r.mult  = RECIP_1;
    r.extra = 1'b0;
    case (n)
      4'd1: r.mult = RECIP_1;
      4'd2: r.mult = RECIP_2;
      4'd3: r.mult = RECIP_3;
      4'd4: r.mult = RECIP_4;
      4'd6: begin
        r.mult  = RECIP_3;
        r.extra = 1'b1;
      end
      4'd9: r.mult = RECIP_9;
      default: r.mult = '0;
    endcase
    return r;
  endfunction

endpackage

### rtl/bmn_front.sv
// front end: pixel counters, row store, column window and result classification
module bmn_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [bmn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmn_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          pix_valid,
  output logic                          pix_ready,
  input  logic [bmn_pkg::PW-1:0]         pix,
  output logic                          ent_valid,
  input  logic                          ent_ready,
  output bmn_pkg::entry_t               ent
);
  import bmn_pkg::*;

  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int W_RST = (MAX_WIDTH < FW_RESET) ? MAX_WIDTH : FW_RESET;
  localparam int H_RST = (MAX_HEIGHT < FH_RESET) ? MAX_HEIGHT : FH_RESET;

  logic [XW-1:0]   w_last, w_last_next;
  logic [YW-1:0]   h_last, h_last_next;
  logic [XW-1:0]   col;
  logic [YW-1:0]   row;
  logic            cfg_hit, in_acc;

  logic            b_valid, b_adv;
  logic [XW-1:0]   b_col;
  logic [YW-1:0]   b_row;
  logic [PW-1:0]   b_pix;

  // each entry holds {row y-2, row y-1} for one column
  logic [2*PW-1:0] rows [MAX_WIDTH];
  logic [2*PW-1:0] rd_data, byp_data, stored, wr_data;
  logic            byp;

  logic [2:0][PW-1:0] win1, win2, cur_col;
  logic x_nz, x_gt1, y_nz, y_gt1, lastcol, lastrow;

  assign in_acc  = pix_valid && pix_ready;
  assign cfg_hit = cfg_valid && (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

  always_comb begin
    w_last_next = w_last;
    h_last_next = h_last;
    if (cfg_valid && cfg_index == REG_FRAME_WIDTH) begin
      if (cfg_data[FW_W-1:0] == '0) begin
        w_last_next = '0;
      end else if (int'(cfg_data[FW_W-1:0]) > MAX_WIDTH) begin
        w_last_next = XW'(MAX_WIDTH - 1);
      end else begin
        w_last_next = XW'(cfg_data[FW_W-1:0] - 1'b1);
      end
    end
    if (cfg_valid && cfg_index == REG_FRAME_HEIGHT) begin
      if (cfg_data[FH_W-1:0] == '0) begin
        h_last_next = '0;
      end else if (int'(cfg_data[FH_W-1:0]) > MAX_HEIGHT) begin
        h_last_next = YW'(MAX_HEIGHT - 1);
      end else begin
        h_last_next = YW'(cfg_data[FH_W-1:0] - 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w_last  <= XW'(W_RST - 1);
      h_last  <= YW'(H_RST - 1);
      col     <= '0;
      row     <= '0;
      b_valid <= 1'b0;
    end else begin
      w_last <= w_last_next;
      h_last <= h_last_next;
      if (cfg_hit) begin
        col <= '0;
        row <= '0;
      end else if (in_acc) begin
        if (col == w_last) begin
          col <= '0;
          row <= (row == h_last) ? '0 : row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end
      if (in_acc) begin
        b_valid <= 1'b1;
      end else if (b_adv) begin
        b_valid <= 1'b0;
      end
    end
  end

  // forward the pending write when the next pixel reads the same column (one-pixel rows)
  assign stored  = byp ? byp_data : rd_data;
  assign wr_data = {stored[PW-1:0], b_pix};

  always_comb begin
    cur_col[0] = stored[2*PW-1:PW];
    cur_col[1] = stored[PW-1:0];
    cur_col[2] = b_pix;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_col    <= col;
      b_row    <= row;
      b_pix    <= pix;
      rd_data  <= rows[col];
      byp      <= b_adv && (b_col == col);
      byp_data <= wr_data;
    end
    if (b_adv) begin
      rows[b_col] <= wr_data;
      win2        <= win1;
      win1        <= cur_col;
    end
  end

  assign x_nz    = (b_col != '0);
  assign x_gt1   = (b_col > XW'(1));
  assign y_nz    = (b_row != '0);
  assign y_gt1   = (b_row > YW'(1));
  assign lastcol = (b_col == w_last);
  assign lastrow = (b_row == h_last);

  always_comb begin
    ent.pres[RES_INNER]  = x_nz && y_nz;
    ent.pres[RES_RIGHT]  = lastcol && y_nz;
    ent.pres[RES_BOTTOM] = lastrow && x_nz;
    ent.pres[RES_CORNER] = lastrow && lastcol;
    ent.cmask   = {1'b1, x_nz, x_gt1};
    ent.rmask   = {1'b1, y_nz, y_gt1};
    ent.col_cur = COL_W'(b_col);
    ent.col_prv = COL_W'(b_col - 1'b1);
    ent.row_cur = ROW_W'(b_row);
    ent.row_prv = ROW_W'(b_row - 1'b1);
    ent.grid[0] = win2;
    ent.grid[1] = win1;
    ent.grid[2] = cur_col;
  end

  // pixels that cause no result retire without using the queue
  assign ent_valid = b_valid && (ent.pres != '0);
  assign b_adv     = b_valid && ((ent.pres == '0) || ent_ready);
  assign pix_ready = !b_valid || b_adv;

endmodule

### rtl/bmn_queue.sv
// short queue of classified pixels between front and back
module bmn_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  bmn_pkg::entry_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output bmn_pkg::entry_t pop_data
);
  import bmn_pkg::*;

  localparam int QAW = $clog2(QDEPTH);

  entry_t         slots [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   count;
  logic           push, pop;

  assign push_ready = (count != (QAW+1)'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

### rtl/bmn_back.sv
// back end: steps through the results of each entry and computes the rounded means
module bmn_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      ent_valid,
  output logic                      ent_ready,
  input  bmn_pkg::entry_t           ent,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [bmn_pkg::PW-1:0]    smoothed,
  output logic [bmn_pkg::COL_W-1:0] out_col,
  output logic [bmn_pkg::ROW_W-1:0] out_row,
  output logic                      run_last,
  output logic                      frame_last
);
  import bmn_pkg::*;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             run_last;
    logic             frame_last;
  } res_tag_t;

  logic [3:0] done, rem, sel;
  logic       pipe_en, issue, last_kind;
  logic [2:0] k_cm, k_rm;
  logic [1:0] nc, nr;
  logic [3:0] k_n;
  logic [2:0][COLSUM_W-1:0] csum;
  res_tag_t   k_tag;
  recip_t     rc;

  logic                     s1_valid, s2_valid, s3_valid;
  logic [2:0][COLSUM_W-1:0] s1_csum;
  logic [3:0]               s1_n;
  res_tag_t                 s1_tag, s2_tag, s3_tag;
  logic [SUM_W-1:0]         s2_t;
  logic [RECIP_W-1:0]       s2_m;
  logic                     s2_x, s3_x;
  logic [PROD_W-1:0]        s3_p;

  assign rem       = ent.pres & ~done;
  assign sel       = rem & (~rem + 4'd1);
  assign pipe_en   = !out_valid || out_ready;
  assign issue     = ent_valid && pipe_en;
  assign last_kind = (rem == sel);
  assign ent_ready = issue && last_kind;

  always_comb begin
    k_cm = ent.cmask & ((sel[RES_RIGHT] || sel[RES_CORNER]) ? 3'b110 : 3'b111);
    // bottom results drop row y-2 and keep rows y-1 and y
    k_rm = ent.rmask & ((sel[RES_BOTTOM] || sel[RES_CORNER]) ? 3'b110 : 3'b111);
    k_tag.col = (sel[RES_INNER] || sel[RES_BOTTOM]) ? ent.col_prv : ent.col_cur;
    k_tag.row = (sel[RES_INNER] || sel[RES_RIGHT]) ? ent.row_prv : ent.row_cur;
    k_tag.run_last   = last_kind;
    k_tag.frame_last = sel[RES_CORNER];
    nc  = 2'($countones(k_cm));
    nr  = 2'($countones(k_rm));
    k_n = {2'b00, nc} * {2'b00, nr};
    for (int c = 0; c < 3; c++) begin
      csum[c] = '0;
      if (k_cm[c]) begin
        csum[c] = (k_rm[0] ? COLSUM_W'(ent.grid[c][0]) : '0)
                + (k_rm[1] ? COLSUM_W'(ent.grid[c][1]) : '0)
                + (k_rm[2] ? COLSUM_W'(ent.grid[c][2]) : '0);
      end
    end
  end

  assign rc = recip_of(s1_n);

  always_ff @(posedge clk) begin
    if (rst) begin
      done      <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        done <= last_kind ? '0 : (done | sel);
      end
      if (pipe_en) begin
        s1_valid  <= ent_valid;
        s2_valid  <= s1_valid;
        s3_valid  <= s2_valid;
        out_valid <= s3_valid;
      end
    end
  end

  // rounding: (2*sum + n) / (2*n) == (sum + n/2) / n, done as a reciprocal multiply
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_csum <= csum;
      s1_n    <= k_n;
      s1_tag  <= k_tag;

      s2_t   <= SUM_W'(s1_csum[0]) + SUM_W'(s1_csum[1]) + SUM_W'(s1_csum[2])
              + SUM_W'(s1_n >> 1);
      s2_m   <= rc.mult;
      s2_x   <= rc.extra;
      s2_tag <= s1_tag;

      s3_p   <= PROD_W'(s2_t) * PROD_W'(s2_m);
      s3_x   <= s2_x;
      s3_tag <= s2_tag;

      smoothed   <= s3_x ? s3_p[QSHIFT+1 +: PW] : s3_p[QSHIFT +: PW];
      out_col    <= s3_tag.col;
      out_row    <= s3_tag.row;
      run_last   <= s3_tag.run_last;
      frame_last <= s3_tag.frame_last;
    end
  end

  a_corner_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_last |-> run_last)
    else $error("frame end result is not the last of its run");

  a_pop_clears_done: assert property (@(posedge clk) disable iff (rst)
    ent_ready |=> (done == '0))
    else $error("result marks not cleared after entry retired");

  a_partial_marks: assert property (@(posedge clk) disable iff (rst)
    issue && !last_kind |=> (done != '0))
    else $error("issued result not marked while entry stays");

endmodule

### rtl/box_mean_3x3_edge_normalized.sv
// top level of the streaming 3x3 box mean filter with edge normalization
// usage:
//   s_* takes raster-order pixels, one per transaction, low 16 bits of s_tdata.
//   m_* gives smoothed results with their column and row; m_tlast marks the
//   last result caused by one input pixel, m_tuser marks the frame's final position.
//   cfg_* writes frame_width (index 0) or frame_height (index 1); any such write
//   restarts the frame at column 0, row 0. write only while the block is idle.
// throughput: one pixel per cycle in, one result per cycle out. a pixel causes
//   0 to 4 results (more at row ends and on the last row); a 4-entry queue
//   between the classifier and the mean pipeline absorbs these bursts, and the
//   input stalls only when it fills.
// path: front pixel register, queue, then stages s1, s2, s3 and the output register.
// stalls: while m_tready is low the mean pipeline holds and the queue fills,
//   then s_tready drops; nothing is dropped or repeated.
// reset: counters to zero, size registers to 1024 x 4096 (clipped to the maximum
//   size); the row store is not cleared since rows from before the current
//   frame are never used.
module box_mean_3x3_edge_normalized #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [15:0]                    s_tdata,   // pixel_in
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [39:0]                    m_tdata,   // smoothed, out_col, out_row, zero pad
  output logic                           m_tlast,
  output logic                           m_tuser,   // frame_last
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bmn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bmn_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bmn_pkg::*;

  entry_t           f_ent, q_ent;
  logic             f_valid, f_ready, q_valid, q_ready;
  logic [PW-1:0]    smoothed;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;

  assign cfg_ready = 1'b1;

  bmn_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_valid (s_tvalid),
    .pix_ready (s_tready),
    .pix       (s_tdata),
    .ent_valid (f_valid),
    .ent_ready (f_ready),
    .ent       (f_ent)
  );

  bmn_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_ent),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_ent)
  );

  bmn_back u_back (
    .clk        (clk),
    .rst        (rst),
    .ent_valid  (q_valid),
    .ent_ready  (q_ready),
    .ent        (q_ent),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .smoothed   (smoothed),
    .out_col    (out_col),
    .out_row    (out_row),
    .run_last   (m_tlast),
    .frame_last (m_tuser)
  );

  assign m_tdata = {2'b00, out_row, out_col, smoothed};

endmodule

### tb/tb.sv
// testbench for the streaming 3x3 box mean filter with edge normalization
`timescale 1ns / 1ps

module tb;
  import bmn_pkg::*;

  localparam int MAX_W         = 1024;
  localparam int MAX_H         = 4096;
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int COL_LSB       = PW;
  localparam int ROW_LSB       = PW + COL_W;

  typedef logic [PW-1:0] nbhd_t [3][3];

  typedef struct packed {
    logic [PW-1:0]    smoothed;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             run_last;
    logic             frame_last;
  } mean_result_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [15:0]           s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [39:0]           m_tdata;
  logic                  m_tlast;
  logic                  m_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // filter state as the testbench tracks it
  logic [PW-1:0] line_older [MAX_W];
  logic [PW-1:0] line_prior [MAX_W];
  logic [PW-1:0] win_cols [6];
  int unsigned   pos_x;
  int unsigned   pos_y;
  int unsigned   reg_width;
  int unsigned   reg_height;

  mean_result_t  pending_means [$];
  int unsigned   fails;
  int unsigned   cycle_count;
  int unsigned   tx_idle_pct;
  int unsigned   rx_idle_pct;
  int unsigned   hold_off_cycles;

  box_mean_3x3_edge_normalized dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic int unsigned clamp_size(input int unsigned v, input int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // rounded mean over the selected columns and rows, ties go up
  function automatic logic [PW-1:0] box_avg(input nbhd_t g, input logic [2:0] cm,
                                            input logic [2:0] rm);
    int unsigned sum;
    int unsigned n;
    sum = 0;
    n   = 0;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        if (cm[c] && rm[r]) begin
          sum += g[c][r];
          n++;
        end
      end
    end
    if (n == 0) return '0;
    return PW'((2 * sum + n) / (2 * n));
  endfunction

  function automatic mean_result_t make_result(input logic [PW-1:0] v, input int unsigned col,
                                               input int unsigned row, input logic flast);
    mean_result_t r;
    r.smoothed   = v;
    r.col        = COL_W'(col);
    r.row        = ROW_W'(row);
    r.run_last   = 1'b0;
    r.frame_last = flast;
    return r;
  endfunction

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    bit hit;
    hit = 1'b1;
    if (idx == REG_FRAME_WIDTH) reg_width = val[FW_W-1:0];
    else if (idx == REG_FRAME_HEIGHT) reg_height = val[FH_W-1:0];
    else hit = 1'b0;
    // any size write restarts the frame
    if (hit) begin
      pos_x = 0;
      pos_y = 0;
    end
  endtask

  task automatic predict_pixel(input logic [PW-1:0] pix);
    int unsigned  w, h, x, y;
    nbhd_t        g;
    logic [2:0]   rmask, cmask, cright;
    bit           lastcol, lastrow;
    mean_result_t burst [$];
    w = clamp_size(reg_width, MAX_W);
    h = clamp_size(reg_height, MAX_H);
    x = (pos_x >= w) ? 0 : pos_x;
    y = (pos_y >= h) ? 0 : pos_y;
    g[0][0] = win_cols[3]; g[0][1] = win_cols[4]; g[0][2] = win_cols[5];
    g[1][0] = win_cols[0]; g[1][1] = win_cols[1]; g[1][2] = win_cols[2];
    g[2][0] = line_older[x]; g[2][1] = line_prior[x]; g[2][2] = pix;
    rmask   = {(y >= 2), (y >= 1), 1'b1};
    rmask   = {rmask[0], rmask[1], rmask[2]};
    cmask   = {1'b1, (x >= 1), (x >= 2)};
    cright  = cmask & 3'b110;
    lastcol = (x == w - 1);
    lastrow = (y == h - 1);
    if (x >= 1 && y >= 1)
      burst.insert(burst.size(), make_result(box_avg(g, cmask, rmask), x - 1, y - 1, 1'b0));
    if (lastcol && y >= 1)
      burst.insert(burst.size(), make_result(box_avg(g, cright, rmask), x, y - 1, 1'b0));
    if (lastrow && x >= 1)
      burst.insert(burst.size(),
                   make_result(box_avg(g, cmask, rmask & 3'b110), x - 1, y, 1'b0));
    if (lastrow && lastcol)
      burst.insert(burst.size(), make_result(box_avg(g, cright, rmask & 3'b110), x, y, 1'b1));
    if (burst.size() > 0) burst[burst.size() - 1].run_last = 1'b1;
    foreach (burst[i]) pending_means.insert(pending_means.size(), burst[i]);
    line_older[x] = line_prior[x];
    line_prior[x] = pix;
    win_cols[3] = win_cols[0];
    win_cols[4] = win_cols[1];
    win_cols[5] = win_cols[2];
    win_cols[0] = g[2][0];
    win_cols[1] = g[2][1];
    win_cols[2] = pix;
    x++;
    if (x >= w) begin
      x = 0;
      y++;
      if (y >= h) y = 0;
    end
    pos_x = x;
    pos_y = y;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      fails++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // input side: register writes and pixel transactions feed the predictor
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) predict_pixel(s_tdata);
    end
  end

  // output side: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    mean_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_means.size() == 0) begin
        fails++;
        $display("%0t: unexpected result: expected none, actual %0d at col %0d row %0d",
                 $time, m_tdata[PW-1:0], m_tdata[COL_LSB +: COL_W], m_tdata[ROW_LSB +: ROW_W]);
      end else begin
        want = pending_means.pop_front();
        check_field("smoothed", want.smoothed, m_tdata[PW-1:0]);
        check_field("out_col", want.col, m_tdata[COL_LSB +: COL_W]);
        check_field("out_row", want.row, m_tdata[ROW_LSB +: ROW_W]);
        check_field("run_last", want.run_last, m_tlast);
        check_field("frame_last", want.frame_last, m_tuser);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("box_mean_3x3_edge_normalized test failed");
      $finish;
    end
  end

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int unsigned pick_idle();
    int unsigned levels [4] = '{0, 10, 30, 60};
    return levels[$urandom_range(0, 3)];
  endfunction

  // receiver: random stalls, plus a long hold-off when a test asks for one
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
        m_tready <= 1'b1;
      end else if ($urandom_range(0, 99) < rx_idle_pct) begin
        m_tready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_pixel(input logic [PW-1:0] pix);
    int unsigned gap;
    gap = ($urandom_range(0, 99) < tx_idle_pct) ? pick_gap() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic logic [PW-1:0] rand_pixel();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return PW'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_run(input int unsigned n);
    repeat (n) send_pixel(rand_pixel());
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // let every predicted result arrive, then allow for pixels still in flight
  task automatic drain();
    s_tvalid <= 1'b0;
    // the last transaction is predicted at the edge just passed
    @(posedge clk);
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // width keeps its reset value of 1024 here
  task automatic test_default_width();
    tx_idle_pct = 10;
    rx_idle_pct = 10;
    write_reg(REG_FRAME_HEIGHT, 1);
    send_run(16);
    drain();
  endtask

  // zero sizes act as a one pixel frame: every pixel is its own mean
  task automatic test_unit_frame();
    logic [PW-1:0] vals [7] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF,
                                16'hAAAA, 16'h5555};
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(REG_FRAME_WIDTH, 0);
    write_reg(REG_FRAME_HEIGHT, 0);
    foreach (vals[i]) send_pixel(vals[i]);
    drain();
  endtask

  // full scale frame, then small values that land on rounding ties
  task automatic test_rounding();
    logic [PW-1:0] ties [9] = '{16'd2, 16'd1, 16'd0, 16'd3, 16'd0, 16'd0, 16'd0, 16'd5,
                                16'd4};
    tx_idle_pct = 30;
    rx_idle_pct = 30;
    write_reg(REG_FRAME_WIDTH, 3);
    write_reg(REG_FRAME_HEIGHT, 3);
    repeat (9) send_pixel('1);
    foreach (ties[i]) send_pixel(ties[i]);
    drain();
  endtask

  task automatic test_oversize_row();
    tx_idle_pct = 10;
    rx_idle_pct = 10;
    write_reg(REG_FRAME_WIDTH, 2047);
    write_reg(REG_FRAME_HEIGHT, 1);
    send_run(16);
    drain();
  endtask

  task automatic test_oversize_column();
    tx_idle_pct = 10;
    rx_idle_pct = 10;
    write_reg(REG_FRAME_WIDTH, 1);
    write_reg(REG_FRAME_HEIGHT, 8191);
    send_run(16);
    drain();
  endtask

  // a write in the middle of a frame must drop the partial rows
  task automatic test_restart();
    tx_idle_pct = 30;
    rx_idle_pct = 30;
    write_reg(REG_FRAME_WIDTH, 5);
    write_reg(REG_FRAME_HEIGHT, 4);
    send_run(12);
    drain();
    write_reg(REG_FRAME_WIDTH, 5);
    send_run(23);
    drain();
    write_reg(REG_FRAME_HEIGHT, 4);
    send_run(20);
    drain();
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_reg(REG_FRAME_WIDTH, 4);
    write_reg(REG_FRAME_HEIGHT, 6);
    hold_off_cycles = 300;
    repeat (2) @(posedge clk);
    send_run(40);
    drain();
  endtask

  task automatic test_random_frames();
    int unsigned sent, w, h, n;
    sent = 0;
    while (sent < 40) begin
      w = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 24) : $urandom_range(0, 10);
      h = $urandom_range(0, 6);
      tx_idle_pct = pick_idle();
      rx_idle_pct = pick_idle();
      if ($urandom_range(0, 1) == 0) begin
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
      end else begin
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_FRAME_WIDTH, w);
      end
      n = clamp_size(w, MAX_W) * clamp_size(h, MAX_H);
      if (n <= 60) n = n * $urandom_range(1, 2);
      // sometimes stop partway into a frame
      if ($urandom_range(0, 2) == 0) n = n + $urandom_range(1, n);
      send_run(n);
      sent += n;
      drain();
    end
  endtask

  initial begin
    rst             <= 1'b1;
    s_tvalid        <= 1'b0;
    s_tdata         <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= REG_FRAME_WIDTH;
    cfg_data        <= '0;
    fails           = 0;
    cycle_count     = 0;
    tx_idle_pct     = 0;
    rx_idle_pct     = 0;
    hold_off_cycles = 0;
    foreach (line_older[i]) begin
      line_older[i] = '0;
      line_prior[i] = '0;
    end
    foreach (win_cols[i]) win_cols[i] = '0;
    pos_x      = 0;
    pos_y      = 0;
    reg_width  = FW_RESET;
    reg_height = FH_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_default_width();
    test_unit_frame();
    test_rounding();
    test_oversize_row();
    test_oversize_column();
    test_restart();
    test_backpressure();
    test_random_frames();

    if (fails == 0) begin
      $display("box_mean_3x3_edge_normalized test passed");
    end else begin
      $display("box_mean_3x3_edge_normalized test failed");
    end
    $finish;
  end

endmodule
